### design/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is high.
`define BLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define BLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/blp_pkg.sv
// Shared types and constants of the landing point predictor.
package blp_pkg;

  localparam int OUT_LIMIT  = 8000000;
  localparam int FRAC_BITS  = 20;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 47;

  localparam logic [23:0] OUT_MAX = 24'(OUT_LIMIT);
  localparam logic [23:0] OUT_MIN = 24'(-OUT_LIMIT);

  localparam logic [16:0] RADIUS_RESET  = 17'd20000;
  localparam logic [26:0] GRAVITY_RESET = 27'd9810000;

  // register index, taken from paddr[2]
  localparam logic REG_RADIUS  = 1'b0;
  localparam logic REG_GRAVITY = 1'b1;

  // per-item data that rides alongside the arithmetic
  typedef struct packed {
    logic signed [21:0] px;
    logic signed [21:0] py;
    logic signed [25:0] vx;
    logic signed [25:0] vy;
    logic signed [25:0] vz;
    logic               bypass;
  } side_t;

endpackage

### design/ballistic_landing_point.sv
// Top level of the ballistic landing point predictor.
// Predicts where a falling ball meets the plate. One item is accepted per cycle unless a
// result waits in the output register. Each item passes 85 register stages: input, one
// multiply stage, one stage that forms the discriminant, 32 square root stages, one stage
// to form the dividend, 47 divider stages, a multiply stage and the output register. The
// whole pipeline advances together whenever the output register is empty or its result is
// being taken, so in_ready drops only while a result waits.
// Registers: radius at byte address 0, gravity at byte address 4; write them only
// while no item is in flight.
module ballistic_landing_point (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [21:0] pos_x,
  input  logic signed [21:0] pos_y,
  input  logic signed [21:0] pos_z,
  input  logic signed [25:0] vel_x,
  input  logic signed [25:0] vel_y,
  input  logic signed [25:0] vel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] land_x,
  output logic signed [23:0] land_y
);

  localparam int SN = blp_pkg::SQRT_STEPS;
  localparam int DN = blp_pkg::DIV_STEPS;

  logic [16:0] radius;
  logic [26:0] gravity;
  logic        en;

  // ---------------- configuration ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius  <= blp_pkg::RADIUS_RESET;
      gravity <= blp_pkg::GRAVITY_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        blp_pkg::REG_RADIUS:  radius  <= pwdata[16:0];
        blp_pkg::REG_GRAVITY: gravity <= pwdata[26:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      blp_pkg::REG_RADIUS:  prdata = {15'd0, radius};
      blp_pkg::REG_GRAVITY: prdata = {5'd0, gravity};
      default:              prdata = 32'd0;
    endcase
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- stage a: height above surface ----------------
  logic signed [22:0] dz_in;
  logic               a_vld;
  blp_pkg::side_t     a_side;
  logic [20:0]        a_dz;
  logic [25:0]        a_avz;

  assign dz_in = 23'(pos_z) - $signed({6'd0, radius});

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.px     <= pos_x;
      a_side.py     <= pos_y;
      a_side.vx     <= vel_x;
      a_side.vy     <= vel_y;
      a_side.vz     <= vel_z;
      a_side.bypass <= dz_in[22] || (dz_in == 23'sd0) || (gravity == 27'd0);
      a_dz          <= dz_in[20:0];
      a_avz         <= vel_z[25] ? 26'(-vel_z) : 26'(vel_z);
    end
  end

  // ---------------- stage b: products ----------------
  logic           b_vld;
  blp_pkg::side_t b_side;
  logic [51:0]    b_sq;
  logic [47:0]    b_gd;

  always_ff @(posedge clk) begin
    if (en) begin
      b_side <= a_side;
      b_sq   <= a_avz * a_avz;
      b_gd   <= gravity * a_dz;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  // element 0 holds the discriminant scaled by 4096
  logic           sq_vld  [0:SN];
  blp_pkg::side_t sq_side [0:SN];
  logic [63:0]    sq_rad  [0:SN];
  logic [35:0]    sq_rem  [0:SN];
  logic [31:0]    sq_root [0:SN];
  logic [51:0]    disc;

  assign disc = b_sq + {3'd0, b_gd, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      sq_side[0] <= b_side;
      sq_rad[0]  <= {disc, 12'd0};
      sq_rem[0]  <= 36'd0;
      sq_root[0] <= 32'd0;
    end
  end

  for (genvar k = 1; k <= SN; k++) begin : g_sqrt
    logic [35:0] r;
    logic [35:0] trial;
    assign r     = {sq_rem[k-1][33:0], sq_rad[k-1][63:62]};
    assign trial = {2'd0, sq_root[k-1], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_side[k] <= sq_side[k-1];
        sq_rad[k]  <= {sq_rad[k-1][61:0], 2'b00};
        if (r >= trial) begin
          sq_rem[k]  <= r - trial;
          sq_root[k] <= {sq_root[k-1][30:0], 1'b1};
        end else begin
          sq_rem[k]  <= r;
          sq_root[k] <= {sq_root[k-1][30:0], 1'b0};
        end
      end
    end
  end

  // ---------------- divider, one quotient bit per stage ----------------
  logic               dv_vld  [0:DN];
  blp_pkg::side_t     dv_side [0:DN];
  logic [46:0]        dv_dvd  [0:DN];
  logic [26:0]        dv_rem  [0:DN];
  logic [46:0]        dv_quo  [0:DN];
  logic signed [34:0] n6;

  // n6 = vz*64 + root, never negative in practice; clamped anyway
  assign n6 = {{3{sq_side[SN].vz[25]}}, sq_side[SN].vz, 6'd0} + $signed({3'd0, sq_root[SN]});

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= sq_side[SN];
      dv_dvd[0]  <= n6[34] ? 47'd0 : {n6[32:0], 14'd0};
      dv_rem[0]  <= 27'd0;
      dv_quo[0]  <= 47'd0;
    end
  end

  for (genvar k = 1; k <= DN; k++) begin : g_div
    logic [27:0] r;
    logic [27:0] dsub;
    assign r    = {dv_rem[k-1], dv_dvd[k-1][46]};
    assign dsub = r - {1'b0, gravity};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_side[k] <= dv_side[k-1];
        dv_dvd[k]  <= {dv_dvd[k-1][45:0], 1'b0};
        if (r >= {1'b0, gravity}) begin
          dv_rem[k] <= dsub[26:0];
          dv_quo[k] <= {dv_quo[k-1][45:0], 1'b1};
        end else begin
          dv_rem[k] <= r[26:0];
          dv_quo[k] <= {dv_quo[k-1][45:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage m: displacement products ----------------
  logic           m_vld;
  blp_pkg::side_t m_side;
  logic [52:0]    m_hx, m_hy;
  logic [45:0]    m_lx, m_ly;
  logic [25:0]    ax, ay;

  assign ax = dv_side[DN].vx[25] ? 26'(-dv_side[DN].vx) : 26'(dv_side[DN].vx);
  assign ay = dv_side[DN].vy[25] ? 26'(-dv_side[DN].vy) : 26'(dv_side[DN].vy);

  always_ff @(posedge clk) begin
    if (en) begin
      m_side <= dv_side[DN];
      m_hx   <= dv_quo[DN][46:20] * ax;
      m_hy   <= dv_quo[DN][46:20] * ay;
      m_lx   <= dv_quo[DN][19:0] * ax;
      m_ly   <= dv_quo[DN][19:0] * ay;
    end
  end

  // ---------------- output stage: round, add, saturate ----------------
  function automatic logic [23:0] land_calc(logic signed [21:0] p, logic neg,
                                            logic [52:0] hi, logic [45:0] lo,
                                            logic bypass);
    logic [46:0]        lr;
    logic [53:0]        mag;
    logic signed [55:0] d;
    logic signed [55:0] s;
    lr  = {1'b0, lo} + 47'(1 << (blp_pkg::FRAC_BITS - 1));
    mag = {1'b0, hi} + 54'(lr[46:20]);
    d   = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    s   = 56'(p) + d;
    if (bypass) s = 56'(p);
    if (s > 56'sd8000000) return blp_pkg::OUT_MAX;
    else if (s < -56'sd8000000) return blp_pkg::OUT_MIN;
    else return s[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      land_x <= land_calc(m_side.px, m_side.vx[25], m_hx, m_lx, m_side.bypass);
      land_y <= land_calc(m_side.py, m_side.vy[25], m_hy, m_ly, m_side.bypass);
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld     <= 1'b0;
      b_vld     <= 1'b0;
      m_vld     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i <= SN; i++) sq_vld[i] <= 1'b0;
      for (int i = 0; i <= DN; i++) dv_vld[i] <= 1'b0;
    end else if (en) begin
      a_vld     <= in_valid;
      b_vld     <= a_vld;
      sq_vld[0] <= b_vld;
      for (int i = 1; i <= SN; i++) sq_vld[i] <= sq_vld[i-1];
      dv_vld[0] <= sq_vld[SN];
      for (int i = 1; i <= DN; i++) dv_vld[i] <= dv_vld[i-1];
      m_vld     <= dv_vld[DN];
      out_valid <= m_vld;
    end
  end

endmodule

### design/blp_checker.sv
// Port-level checker for the landing point predictor, bound to the top level.
`include "assert_macros.svh"

module blp_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] land_x,
  input logic signed [23:0] land_y
);

  localparam logic signed [23:0] LIM = 24'sd8000000;

  logic x_ok;
  logic y_ok;

  assign x_ok = (land_x <= LIM) && (land_x >= -LIM);
  assign y_ok = (land_y <= LIM) && (land_y >= -LIM);

  `BLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BLP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable({land_x, land_y}), "result changed")
  `BLP_ASSERT(a_ready_link, in_ready == (!out_valid || out_ready), "in_ready mismatch")
  `BLP_ASSERT(a_range, out_valid |-> x_ok && y_ok, "result out of range")
  `BLP_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind ballistic_landing_point blp_checker u_blp_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .land_x    (land_x),
  .land_y    (land_y)
);
